// ===== design/bmlt_pkg.sv =====
// package for the bounded multi list table
// holds operation and status codes, sequencer states and sizing constants
`timescale 1ns / 1ps

package bmlt_pkg;

    localparam int NUM_LISTS_DEF    = 10;
    localparam int MAX_CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_APPEND   = 3'd1,
        OP_DEL_LAST = 3'd2,
        OP_DEL_VAL  = 3'd3,
        OP_RESIZE   = 3'd4,
        OP_READ     = 3'd5,
        OP_READ_SRT = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_BAD_SLOT     = 4'd1,
        ST_EXISTS       = 4'd2,
        ST_BAD_SIZE     = 4'd3,
        ST_NO_MEMORY    = 4'd4,
        ST_FULL         = 4'd5,
        ST_NONE         = 4'd6,
        ST_EMPTY        = 4'd7,
        ST_NOT_FOUND    = 4'd8,
        ST_BAD_NEW_SIZE = 4'd9
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,     // waiting for an item
        S_DECODE,   // checks and simple operations
        S_FIND_RD,  // issue read for search
        S_FIND_CMP, // compare read word
        S_SHIFT_RD, // read next word for shift down
        S_SHIFT_WR, // write it one place lower
        S_COPY_RD,  // read word into scratch
        S_COPY_WR,  // latch word into scratch
        S_SORT,     // one compare/swap step
        S_EMIT,     // present one result
        S_WAIT_OUT  // final result waiting to be taken
    } state_t;

endpackage

// ===== design/bmlt_store.sv =====
// element store: one word array, one write port, one registered read port
// depends on bmlt_pkg for nothing beyond widths handed in
`timescale 1ns / 1ps

module bmlt_store #(
    parameter int DEPTH = 160,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bounded_multi_list_table.sv =====
// bounded multi list table: NUM_LISTS lists of signed words with status codes
// top level; uses bmlt_pkg and bmlt_store
//
// Each item is one operation on one slot (create, append, delete last, delete
// first match, resize, read in order, read sorted). The operation kind travels
// on s_tuser. Slots are numbered from 1. One small sequencer drives the
// element store and a 32-bit signed less-than compare for sorting. Simple
// operations go from acceptance through decode to a held result. Delete value
// spends a read and a compare state per word searched plus a read and a write
// state per word moved; a read copies each word into a scratch row through a
// read and a latch state, plus, when sorted, bubble sweeps of n-1 compare/swap
// steps each, one step per cycle, repeated until a sweep makes no swap (at most
// n sweeps, n*(n-1) steps), then the results go out in turn as each is taken.
// The block takes no new item until the last result of the current one has gone
// out.
`timescale 1ns / 1ps

module bounded_multi_list_table #(
    parameter int NUM_LISTS    = bmlt_pkg::NUM_LISTS_DEF,
    parameter int MAX_CAPACITY = bmlt_pkg::MAX_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic [47:0] s_tdata,   // slot[3:0], value[35:4], amount[43:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[3:0], data_value[35:4], element_count[40:36]
    output logic        m_tlast
);

    localparam int CW    = $clog2(MAX_CAPACITY + 1);     // count width
    localparam int IW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int DEPTH = NUM_LISTS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    bmlt_pkg::state_t state_reg, state_next;

    // per-slot control state
    logic            exists_reg [NUM_LISTS];
    logic [CW-1:0]   cap_reg    [NUM_LISTS];
    logic [CW-1:0]   cnt_reg    [NUM_LISTS];

    // item being worked on
    bmlt_pkg::op_t   op_reg;
    logic [SW-1:0]   sidx_reg;
    logic [31:0]     val_reg;
    logic [7:0]      amt_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            swapped_reg, swapped_next;
    logic [31:0]     tmp_reg [MAX_CAPACITY];

    // output register
    logic [3:0]      o_status_reg;
    logic [31:0]     o_data_reg;
    logic [CW-1:0]   o_cnt_reg;
    logic            o_last_reg;

    // store port
    logic            st_we;
    logic [AW-1:0]   st_waddr, st_raddr;
    logic [31:0]     st_wdata, st_rdata;

    logic [AW-1:0]   base;
    logic [2:0]      in_kind;
    logic [3:0]      in_slot;
    logic            slot_ok;
    logic signed [8:0] want;
    logic            out_take;
    logic            lt_swap;

    // read out path
    logic [31:0]     emit_word;
    logic            in_emit;
    logic [31:0]     m_tdata_data;
    logic            m_tlast_emit;

    assign in_kind  = s_tuser;
    assign in_slot  = s_tdata[3:0];
    assign base     = AW'(sidx_reg) * AW'(MAX_CAPACITY);
    assign slot_ok  = (in_slot >= 4'd1) && (32'(in_slot) <= NUM_LISTS);
    assign want     = $signed({1'b0, 8'(cap_reg[sidx_reg])}) + $signed({amt_reg[7], amt_reg});
    assign out_take = m_tvalid && m_tready;

    // compare unit: signed less-than of neighboring scratch words
    assign lt_swap  = $signed(tmp_reg[IW'(j_reg) + IW'(1)]) < $signed(tmp_reg[IW'(j_reg)]);

    bmlt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign s_tready = (state_reg == bmlt_pkg::S_IDLE);
    assign m_tvalid = (state_reg == bmlt_pkg::S_EMIT) || (state_reg == bmlt_pkg::S_WAIT_OUT);
    assign m_tdata  = {7'd0, 5'(o_cnt_reg), m_tdata_data, o_status_reg};
    assign m_tlast  = m_tlast_emit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmlt_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_kind == bmlt_pkg::OP_NOP)
                        state_next = bmlt_pkg::S_IDLE;
                    else if (!slot_ok)
                        state_next = bmlt_pkg::S_WAIT_OUT;
                    else
                        state_next = bmlt_pkg::S_DECODE;
                end
            end
            bmlt_pkg::S_DECODE:
            begin
                state_next = bmlt_pkg::S_WAIT_OUT;
                if (exists_reg[sidx_reg] && n_reg != '0)
                begin
                    if (op_reg == bmlt_pkg::OP_DEL_VAL)
                        state_next = bmlt_pkg::S_FIND_RD;
                    else if (op_reg == bmlt_pkg::OP_READ || op_reg == bmlt_pkg::OP_READ_SRT)
                        state_next = bmlt_pkg::S_COPY_RD;
                end
            end
            bmlt_pkg::S_FIND_RD:  state_next = bmlt_pkg::S_FIND_CMP;
            bmlt_pkg::S_FIND_CMP:
            begin
                if (st_rdata == val_reg)
                    state_next = (i_reg + CW'(1) < n_reg) ? bmlt_pkg::S_SHIFT_RD
                                                          : bmlt_pkg::S_WAIT_OUT;
                else if (i_reg + CW'(1) < n_reg)
                    state_next = bmlt_pkg::S_FIND_RD;
                else
                    state_next = bmlt_pkg::S_WAIT_OUT;
            end
            bmlt_pkg::S_SHIFT_RD: state_next = bmlt_pkg::S_SHIFT_WR;
            bmlt_pkg::S_SHIFT_WR:
                state_next = (i_reg + CW'(2) < n_reg) ? bmlt_pkg::S_SHIFT_RD
                                                      : bmlt_pkg::S_WAIT_OUT;
            bmlt_pkg::S_COPY_RD:  state_next = bmlt_pkg::S_COPY_WR;
            bmlt_pkg::S_COPY_WR:
            begin
                if (i_reg + CW'(1) < n_reg)
                    state_next = bmlt_pkg::S_COPY_RD;
                else if (op_reg == bmlt_pkg::OP_READ_SRT && n_reg > CW'(1))
                    state_next = bmlt_pkg::S_SORT;
                else
                    state_next = bmlt_pkg::S_EMIT;
            end
            bmlt_pkg::S_SORT:
            begin
                if (j_reg + CW'(2) >= n_reg && !(swapped_reg || lt_swap))
                    state_next = bmlt_pkg::S_EMIT;
            end
            bmlt_pkg::S_EMIT:
            begin
                if (m_tready && i_reg + CW'(1) >= n_reg)
                    state_next = bmlt_pkg::S_IDLE;
            end
            bmlt_pkg::S_WAIT_OUT:
            begin
                if (m_tready)
                    state_next = bmlt_pkg::S_IDLE;
            end
            default: state_next = bmlt_pkg::S_IDLE;
        endcase
    end

    // store port and counters
    always_comb
    begin
        st_we        = 1'b0;
        st_waddr     = base + AW'(n_reg);
        st_wdata     = val_reg;
        st_raddr     = base + AW'(i_reg);
        i_next       = i_reg;
        j_next       = j_reg;
        swapped_next = swapped_reg;
        case (state_reg)
            bmlt_pkg::S_DECODE:
            begin
                i_next = '0;
                j_next = '0;
                swapped_next = 1'b0;
                if (op_reg == bmlt_pkg::OP_APPEND && exists_reg[sidx_reg]
                    && n_reg < cap_reg[sidx_reg])
                    st_we = 1'b1;
            end
            bmlt_pkg::S_FIND_CMP:
            begin
                if (st_rdata != val_reg)
                    i_next = i_reg + CW'(1);
            end
            bmlt_pkg::S_SHIFT_RD:
                st_raddr = base + AW'(i_reg) + AW'(1);
            bmlt_pkg::S_SHIFT_WR:
            begin
                st_we    = 1'b1;
                st_waddr = base + AW'(i_reg);
                st_wdata = st_rdata;
                i_next   = i_reg + CW'(1);
            end
            bmlt_pkg::S_COPY_WR:
                i_next = (i_reg + CW'(1) < n_reg) ? i_reg + CW'(1) : '0;
            bmlt_pkg::S_SORT:
            begin
                if (j_reg + CW'(2) >= n_reg)
                begin
                    j_next = '0;
                    swapped_next = 1'b0;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    swapped_next = swapped_reg || lt_swap;
                end
            end
            bmlt_pkg::S_EMIT:
            begin
                if (m_tready)
                    i_next = i_reg + CW'(1);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bmlt_pkg::S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            swapped_reg <= 1'b0;
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                exists_reg[k] <= 1'b0;
                cap_reg[k]    <= '0;
                cnt_reg[k]    <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            swapped_reg <= swapped_next;
            if (state_reg == bmlt_pkg::S_DECODE)
            begin
                case (op_reg)
                    bmlt_pkg::OP_CREATE:
                        if (!exists_reg[sidx_reg] && !amt_reg[7] && amt_reg != 8'd0
                            && 32'(amt_reg) <= MAX_CAPACITY)
                        begin
                            exists_reg[sidx_reg] <= 1'b1;
                            cap_reg[sidx_reg]    <= CW'(amt_reg);
                            cnt_reg[sidx_reg]    <= '0;
                        end
                    bmlt_pkg::OP_APPEND:
                        if (exists_reg[sidx_reg] && n_reg < cap_reg[sidx_reg])
                            cnt_reg[sidx_reg] <= n_reg + CW'(1);
                    bmlt_pkg::OP_DEL_LAST:
                        if (exists_reg[sidx_reg] && n_reg != '0)
                            cnt_reg[sidx_reg] <= n_reg - CW'(1);
                    bmlt_pkg::OP_RESIZE:
                        if (exists_reg[sidx_reg] && want >= 9'sd1
                            && want <= $signed(9'(MAX_CAPACITY)))
                        begin
                            cap_reg[sidx_reg] <= CW'(want);
                            if (32'(n_reg) > 32'(want))
                                cnt_reg[sidx_reg] <= CW'(want);
                        end
                    default: ;
                endcase
            end
            if (state_reg == bmlt_pkg::S_FIND_CMP && st_rdata == val_reg)
                cnt_reg[sidx_reg] <= n_reg - CW'(1);
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bmlt_pkg::S_IDLE:
            begin
                op_reg       <= bmlt_pkg::op_t'(in_kind);
                sidx_reg     <= SW'(in_slot - 4'd1);
                val_reg      <= s_tdata[35:4];
                amt_reg      <= s_tdata[43:36];
                o_status_reg <= bmlt_pkg::ST_BAD_SLOT;
                o_data_reg   <= '0;
                o_cnt_reg    <= '0;
                o_last_reg   <= 1'b1;
            end
            bmlt_pkg::S_DECODE:
            begin
                o_data_reg <= '0;
                o_last_reg <= 1'b1;
                o_cnt_reg  <= n_reg;
                if (op_reg == bmlt_pkg::OP_CREATE)
                begin
                    if (exists_reg[sidx_reg])
                        o_status_reg <= bmlt_pkg::ST_EXISTS;
                    else if (amt_reg[7] || amt_reg == 8'd0)
                    begin
                        o_status_reg <= bmlt_pkg::ST_BAD_SIZE;
                        o_cnt_reg    <= '0;
                    end
                    else if (32'(amt_reg) > MAX_CAPACITY)
                    begin
                        o_status_reg <= bmlt_pkg::ST_NO_MEMORY;
                        o_cnt_reg    <= '0;
                    end
                    else
                    begin
                        o_status_reg <= bmlt_pkg::ST_OK;
                        o_cnt_reg    <= '0;
                    end
                end
                else if (!exists_reg[sidx_reg])
                begin
                    o_status_reg <= bmlt_pkg::ST_NONE;
                    o_cnt_reg    <= '0;
                end
                else
                begin
                    case (op_reg)
                        bmlt_pkg::OP_APPEND:
                            if (n_reg < cap_reg[sidx_reg])
                            begin
                                o_status_reg <= bmlt_pkg::ST_OK;
                                o_cnt_reg    <= n_reg + CW'(1);
                            end
                            else
                                o_status_reg <= bmlt_pkg::ST_FULL;
                        bmlt_pkg::OP_DEL_LAST:
                            if (n_reg != '0)
                            begin
                                o_status_reg <= bmlt_pkg::ST_OK;
                                o_cnt_reg    <= n_reg - CW'(1);
                            end
                            else
                                o_status_reg <= bmlt_pkg::ST_EMPTY;
                        bmlt_pkg::OP_DEL_VAL:
                            o_status_reg <= (n_reg != '0) ? bmlt_pkg::ST_NOT_FOUND
                                                          : bmlt_pkg::ST_EMPTY;
                        bmlt_pkg::OP_RESIZE:
                            if (want < 9'sd1)
                                o_status_reg <= bmlt_pkg::ST_BAD_NEW_SIZE;
                            else if (want > $signed(9'(MAX_CAPACITY)))
                                o_status_reg <= bmlt_pkg::ST_NO_MEMORY;
                            else
                            begin
                                o_status_reg <= bmlt_pkg::ST_OK;
                                if (32'(n_reg) > 32'(want))
                                    o_cnt_reg <= CW'(want);
                            end
                        default:
                            o_status_reg <= bmlt_pkg::ST_EMPTY;
                    endcase
                end
            end
            bmlt_pkg::S_FIND_CMP:
                if (st_rdata == val_reg)
                begin
                    o_status_reg <= bmlt_pkg::ST_OK;
                    o_cnt_reg    <= n_reg - CW'(1);
                end
            bmlt_pkg::S_COPY_WR:
            begin
                tmp_reg[IW'(i_reg)] <= st_rdata;
                if (i_reg + CW'(1) >= n_reg)
                begin
                    // preload status and count for the read results
                    o_status_reg <= bmlt_pkg::ST_OK;
                    o_cnt_reg    <= n_reg;
                end
            end
            bmlt_pkg::S_SORT:
                if (lt_swap)
                begin
                    tmp_reg[IW'(j_reg)]           <= tmp_reg[IW'(j_reg) + IW'(1)];
                    tmp_reg[IW'(j_reg) + IW'(1)]  <= tmp_reg[IW'(j_reg)];
                end
            default: ;
        endcase
        // latch slot count once the slot index is known
        if (state_reg == bmlt_pkg::S_IDLE)
            n_reg <= cnt_reg[SW'(in_slot - 4'd1)];
    end

    // result word during read out comes straight from the scratch row
    assign emit_word = tmp_reg[IW'(i_reg)];

    // read results override data and last
    assign in_emit = (state_reg == bmlt_pkg::S_EMIT);

    always_comb
    begin
        if (in_emit)
        begin
            m_tdata_data = emit_word;
            m_tlast_emit = (i_reg + CW'(1) >= n_reg);
        end
        else
        begin
            m_tdata_data = o_data_reg;
            m_tlast_emit = o_last_reg;
        end
    end

    // assertions
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bmlt_pkg::S_IDLE && 32'(sidx_reg) < NUM_LISTS)
            |-> (cnt_reg[sidx_reg] <= cap_reg[sidx_reg]))
        else $error("slot count above capacity");
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && m_tlast) |=> s_tready)
        else $error("block not idle after final result");
    a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmlt_pkg::S_WAIT_OUT) |-> o_last_reg)
        else $error("single result without last");

endmodule
